// ===== rtl/gpr_pkg.sv =====
package gpr_pkg;

	// Fixed font geometry
	localparam int GLYPH_ENTRIES    = 96;
	localparam int GI_W             = $clog2(GLYPH_ENTRIES);
	localparam int BITMAP_BYTES_DEF = 16384;

	// Pixel index: 12-bit start + 31 * 4095 + 255 needs 18 bits
	localparam int PIX_W = 18;

	localparam int PADDR_W = 4;

	localparam logic [7:0] FIRST_GLYPH  = 8'h21;
	localparam logic [7:0] LAST_GLYPH   = 8'h7e;
	localparam logic [7:0] TAB_CODE     = 8'h09;
	localparam logic [7:0] TAB_SPAN     = 8'(32 << 2);
	localparam logic [7:0] SPACE_NORMAL = 8'd5;
	localparam logic [7:0] SPACE_DOUBLE = 8'd8;
	localparam logic [7:0] NIBBLE_MASK  = 8'h0f;
	localparam logic [7:0] FULL_ALPHA   = 8'hff;
	localparam logic [7:0] ADV_MAX      = 8'hff;

	localparam logic [23:0] COLOUR_RESET     = 24'hffffff;
	localparam logic [11:0] ROW_PIXELS_RESET = 12'd1024;
	localparam logic [4:0]  HEIGHT_RESET     = 5'd16;

	typedef enum logic [1:0] {
		CMD_LOAD_START  = 2'd0,
		CMD_LOAD_BITMAP = 2'd1,
		CMD_MEASURE     = 2'd2,
		CMD_RENDER      = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_COLOUR     = 2'd0,
		REG_ROW_PIXELS = 2'd1,
		REG_HEIGHT     = 2'd2
	} reg_idx_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [13:0] table_index;
		logic [11:0] table_value;
		logic [7:0]  character;
		logic        double_size;
		logic [7:0]  column;
		logic [4:0]  row;
		logic [13:0] line_byte_offset;
	} in_item_t;

	typedef struct packed {
		logic [7:0] advance;
		logic       pixel_write;
		logic [7:0] pixel_byte0;
		logic [7:0] pixel_byte1;
		logic [7:0] pixel_byte2;
		logic [7:0] pixel_alpha;
	} out_item_t;

	typedef struct packed {
		logic [23:0] text_colour;
		logic [11:0] bitmap_row_pixels;
		logic [4:0]  glyph_height;
	} cfg_t;

endpackage

// ===== rtl/gpr_regs.sv =====
module gpr_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gpr_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output gpr_pkg::cfg_t                cfg
);

	gpr_pkg::cfg_t     cfg_q;
	gpr_pkg::reg_idx_t idx;
	logic              wr_en;

	assign pready = 1'b1;
	assign idx    = gpr_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.text_colour       <= gpr_pkg::COLOUR_RESET;
			cfg_q.bitmap_row_pixels <= gpr_pkg::ROW_PIXELS_RESET;
			cfg_q.glyph_height      <= gpr_pkg::HEIGHT_RESET;
		end else if (wr_en) begin
			unique case (idx)
				gpr_pkg::REG_COLOUR:     cfg_q.text_colour       <= pwdata[23:0];
				gpr_pkg::REG_ROW_PIXELS: cfg_q.bitmap_row_pixels <= pwdata[11:0];
				gpr_pkg::REG_HEIGHT:     cfg_q.glyph_height      <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			gpr_pkg::REG_COLOUR:     prdata = {8'd0, cfg_q.text_colour};
			gpr_pkg::REG_ROW_PIXELS: prdata = {20'd0, cfg_q.bitmap_row_pixels};
			gpr_pkg::REG_HEIGHT:     prdata = {27'd0, cfg_q.glyph_height};
			default:                 prdata = 32'd0;
		endcase
	end

endmodule

// ===== rtl/gpr_bitmap_ram.sv =====
module gpr_bitmap_ram #(
	parameter int DEPTH = gpr_pkg::BITMAP_BYTES_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [7:0]               wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [7:0]               rdata
);

	logic [7:0] mem [DEPTH];

	// read-before-write on a shared address
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/glyph_pixel_renderer.sv =====
// Antialiased proportional font renderer. Load the glyph start table
// (cmd 0) and the packed 4-bit bitmap (cmd 1) first, then send measure
// (cmd 2) or render (cmd 3) transfers; every request transfer yields one
// response transfer, in order. The unit takes one request per clock
// unless a waiting response stalls it: the start table is read at the
// request transfer, the bitmap address is formed and the bitmap RAM read
// in the next stage, and nibble scaling fills the output register in the
// last. Neither store is cleared after reset, so no clearing pass delays
// the first request; entries that are read must have been loaded. The user
// must write configuration over the APB port only while idle; the block
// itself does not enforce it.
module glyph_pixel_renderer #(
	parameter int BITMAP_BYTES = gpr_pkg::BITMAP_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gpr_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// request channel
	input  logic                        req_valid,
	output logic                        req_ready,
	input  gpr_pkg::in_item_t           req,
	// response channel
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output gpr_pkg::out_item_t          rsp
);

	localparam int BM_AW = $clog2(BITMAP_BYTES);
	localparam logic [gpr_pkg::PIX_W-1:0] BM_LIMIT = gpr_pkg::PIX_W'(BITMAP_BYTES);

	gpr_pkg::cfg_t cfg;

	gpr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// ------------------------------------------------------------------
	// Stall control: each stage moves when the one after it is empty or
	// moving, so bubbles collapse while a response waits.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;
	logic accept;

	assign en3       = !v_s3 || rsp_ready;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign req_ready = en1;
	assign accept    = req_valid && en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= req_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// ------------------------------------------------------------------
	// Glyph start table: one write port, two read ports (own start and
	// the next glyph's start), read at the request transfer.
	// ------------------------------------------------------------------
	logic [11:0]              start_mem [gpr_pkg::GLYPH_ENTRIES];
	logic [gpr_pkg::GI_W-1:0] gi, gi_nx;
	logic                     start_we;
	logic [11:0]              start_s1, next_s1;
	gpr_pkg::in_item_t        item_s1;

	assign gi       = gpr_pkg::GI_W'(req.character - gpr_pkg::FIRST_GLYPH);
	assign gi_nx    = gi + 1'b1;
	assign start_we = accept && (req.cmd == gpr_pkg::CMD_LOAD_START)
		&& (req.table_index < 14'(gpr_pkg::GLYPH_ENTRIES));

	always_ff @(posedge clk) begin
		if (start_we) begin
			start_mem[gpr_pkg::GI_W'(req.table_index)] <= req.table_value;
		end
		if (en1) begin
			start_s1 <= start_mem[gi];
			next_s1  <= start_mem[gi_nx];
			item_s1  <= req;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: glyph width, advance, bitmap address.
	// ------------------------------------------------------------------
	logic                      is_glyph;
	logic [11:0]               w_n;
	logic [12:0]               w_d;
	logic [5:0]                h_d;
	logic [6:0]                tab_pos;
	logic [7:0]                tab_adv;
	logic [7:0]                adv;
	logic                      in_glyph;
	logic [4:0]                gr;
	logic [7:0]                gc;
	logic [16:0]               row_base;
	logic [gpr_pkg::PIX_W-1:0] pix;
	logic [gpr_pkg::PIX_W-1:0] byte_idx;
	logic                      in_bm;
	logic                      cand;

	always_comb begin
		is_glyph = (item_s1.character >= gpr_pkg::FIRST_GLYPH)
			&& (item_s1.character <= gpr_pkg::LAST_GLYPH);

		// descending starts give an empty glyph
		w_n = (next_s1 >= start_s1) ? (next_s1 - start_s1) : 12'd0;
		w_d = item_s1.double_size ? {w_n, 1'b0} : {1'b0, w_n};
		h_d = item_s1.double_size ? {cfg.glyph_height, 1'b0} : {1'b0, cfg.glyph_height};

		// tab: distance to the next 128-byte stop, in 4-byte pixels
		tab_pos = item_s1.line_byte_offset[6:0] + 7'd1;
		tab_adv = (gpr_pkg::TAB_SPAN - {1'b0, tab_pos}) >> 2;

		if (item_s1.cmd != gpr_pkg::CMD_MEASURE) begin
			adv = 8'd0;
		end else if (item_s1.character == gpr_pkg::TAB_CODE) begin
			adv = tab_adv;
		end else if (!is_glyph) begin
			adv = item_s1.double_size ? gpr_pkg::SPACE_DOUBLE : gpr_pkg::SPACE_NORMAL;
		end else if (w_d > 13'(gpr_pkg::ADV_MAX)) begin
			adv = gpr_pkg::ADV_MAX;
		end else begin
			adv = w_d[7:0];
		end

		in_glyph = ({5'd0, item_s1.column} < w_d) && ({1'b0, item_s1.row} < h_d);
		gr       = item_s1.double_size ? (item_s1.row >> 1) : item_s1.row;
		gc       = item_s1.double_size ? (item_s1.column >> 1) : item_s1.column;

		row_base = 17'(gr) * 17'(cfg.bitmap_row_pixels);
		pix      = gpr_pkg::PIX_W'(start_s1) + gpr_pkg::PIX_W'(row_base)
			+ gpr_pkg::PIX_W'(gc);
		byte_idx = pix >> 1;
		in_bm    = byte_idx < BM_LIMIT;

		cand = (item_s1.cmd == gpr_pkg::CMD_RENDER) && is_glyph && in_glyph && in_bm;
	end

	// ------------------------------------------------------------------
	// Bitmap RAM: loads write at the request transfer, pixel reads issue
	// as the item leaves stage 1.
	// ------------------------------------------------------------------
	logic             bm_we;
	logic [BM_AW-1:0] bm_waddr;
	logic [7:0]       bm_rdata;

	assign bm_we = accept && (req.cmd == gpr_pkg::CMD_LOAD_BITMAP)
		&& (gpr_pkg::PIX_W'(req.table_index) < BM_LIMIT);
	assign bm_waddr = BM_AW'(req.table_index);

	gpr_bitmap_ram #(
		.DEPTH (BITMAP_BYTES)
	) u_bitmap (
		.clk   (clk),
		.we    (bm_we),
		.waddr (bm_waddr),
		.wdata (req.table_value[7:0]),
		.re    (en2),
		.raddr (BM_AW'(byte_idx)),
		.rdata (bm_rdata)
	);

	logic [7:0] adv_s2;
	logic       cand_s2;
	logic       odd_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			adv_s2  <= adv;
			cand_s2 <= cand;
			odd_s2  <= pix[0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: nibble pick (high nibble for even pixels) and scaling.
	// ------------------------------------------------------------------
	logic [3:0]         nib;
	logic               wr;
	logic [11:0]        p0, p1, p2;
	gpr_pkg::out_item_t res;

	always_comb begin
		nib = 4'((odd_s2 ? bm_rdata : (bm_rdata >> 4)) & gpr_pkg::NIBBLE_MASK);
		wr  = cand_s2 && (nib != 4'd0);
		p0  = 12'(nib) * 12'(cfg.text_colour[7:0]);
		p1  = 12'(nib) * 12'(cfg.text_colour[15:8]);
		p2  = 12'(nib) * 12'(cfg.text_colour[23:16]);

		res.advance     = adv_s2;
		res.pixel_write = wr;
		res.pixel_byte0 = wr ? p0[11:4] : 8'd0;
		res.pixel_byte1 = wr ? p1[11:4] : 8'd0;
		res.pixel_byte2 = wr ? p2[11:4] : 8'd0;
		res.pixel_alpha = wr ? gpr_pkg::FULL_ALPHA : 8'd0;
	end

	gpr_pkg::out_item_t rsp_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			rsp_s3 <= res;
		end
	end

	assign rsp_valid = v_s3;
	assign rsp       = rsp_s3;

endmodule
